### src/fcc_pkg.sv
package fcc_pkg;

  // fixed field widths
  localparam int OpWidth          = 2;
  localparam int SampleIndexWidth = 10;
  localparam int SampleFieldWidth = 16;
  localparam int LagWidth         = 11;
  localparam int LenWidth         = 11;
  localparam int AccWidth         = 42;

  // stream packing
  localparam int InDataWidth  = 40;
  localparam int OutDataWidth = 56;
  localparam int InIndexLsb   = 0;
  localparam int InValueLsb   = InIndexLsb + SampleIndexWidth;
  localparam int InLagLsb     = InValueLsb + SampleFieldWidth;
  localparam int OutPadWidth  = OutDataWidth - AccWidth - LagWidth;

  // configuration port
  localparam int CfgIndexWidth = 1;
  localparam int CfgDataWidth  = LenWidth;
  localparam logic [CfgIndexWidth-1:0] CfgTemplateLength = 1'b0;
  localparam logic [CfgIndexWidth-1:0] CfgSignalLength   = 1'b1;
  localparam logic [LenWidth-1:0]      LenReset          = 11'd1024;

  // defaults for the top-level parameters
  localparam int DefaultMaxLength   = 1024;
  localparam int DefaultSampleWidth = 16;

  // command queue between front and back
  localparam int QueueDepth = 2;

  typedef enum logic [OpWidth-1:0] {
    OP_LOAD_TEMPLATE = 2'd0,
    OP_LOAD_SIGNAL   = 2'd1,
    OP_COMPUTE       = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_LOAD_TEMPLATE,
    CMD_LOAD_SIGNAL,
    CMD_COMPUTE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                   kind;
    logic [SampleIndexWidth-1:0] addr;
    logic [SampleFieldWidth-1:0] value;
    logic [LagWidth-1:0]         lag;
    logic                        err;
    logic                        is_last;
    logic [LenWidth-1:0]         h_start;
    logic [LenWidth-1:0]         x_start;
    logic [LenWidth-1:0]         count;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_FLUSH,
    S_EMIT
  } back_state_e;

endpackage

### src/full_cross_correlation.sv
// full cross-correlation of a stored template h and a stored signal x
//
// input stream: tuser carries the operation (load template sample, load signal
// sample, compute one lag); tdata carries sample position, sample value and lag.
// loads write one entry of the template or signal store and give no output.
// a compute transaction returns y[lag] = sum of h[Lh-1-lag+j] * x[j] over the
// overlap, accumulated exactly in 42 bits, with the lag echoed, tlast set on
// the final lag Lh+Lx-2 and tuser set (value zero) for a lag past that.
// the config channel sets the template and signal lengths; write it only while
// no transaction is in flight.
// a two-entry command queue sits between the input decode and the
// multiply-accumulate engine, so input is taken while a lag is being worked on.
// a lag is worked through with one store read and one multiply-accumulate per
// cycle over its overlap, then the pipeline is flushed and the result emitted.
// reset sets both lengths to 1024 and empties the queue; the stores are not
// cleared and must be loaded before use. a stalled output holds its result; the
// engine goes on with later commands and waits only when its next result is ready.
module full_cross_correlation #(
  parameter int MaxLength   = fcc_pkg::DefaultMaxLength,
  parameter int SampleWidth = fcc_pkg::DefaultSampleWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sample_index, sample_value, lag, zero pad
  input  logic [fcc_pkg::InDataWidth-1:0]     s_axis_tdata,
  // operation
  input  logic [fcc_pkg::OpWidth-1:0]         s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // correlation_value, result_lag, zero pad
  output logic [fcc_pkg::OutDataWidth-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast,
  // status
  output logic                                m_axis_tuser,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fcc_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [fcc_pkg::CfgDataWidth-1:0]    cfg_data_i
);

  fcc_pkg::cmd_t push_cmd, pop_cmd;
  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [fcc_pkg::AccWidth-1:0] corr_value;
  logic [fcc_pkg::LagWidth-1:0] res_lag;

  fcc_front #(
    .MaxLength(MaxLength)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_index_i   (s_axis_tdata[fcc_pkg::InValueLsb-1:fcc_pkg::InIndexLsb]),
    .in_value_i   (s_axis_tdata[fcc_pkg::InLagLsb-1:fcc_pkg::InValueLsb]),
    .in_lag_i     (s_axis_tdata[fcc_pkg::InLagLsb+fcc_pkg::LagWidth-1:fcc_pkg::InLagLsb]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  fcc_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  fcc_back #(
    .MaxLength   (MaxLength),
    .SampleWidth (SampleWidth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_cmd_i    (pop_cmd),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (corr_value),
    .out_lag_o    (res_lag),
    .out_last_o   (m_axis_tlast),
    .out_status_o (m_axis_tuser)
  );

  assign m_axis_tdata = {{fcc_pkg::OutPadWidth{1'b0}}, res_lag, corr_value};

endmodule

### src/fcc_front.sv
module fcc_front #(
  parameter int MaxLength = fcc_pkg::DefaultMaxLength
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [fcc_pkg::OpWidth-1:0]           in_op_i,
  input  logic [fcc_pkg::SampleIndexWidth-1:0]  in_index_i,
  input  logic [fcc_pkg::SampleFieldWidth-1:0]  in_value_i,
  input  logic [fcc_pkg::LagWidth-1:0]          in_lag_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [fcc_pkg::CfgIndexWidth-1:0]     cfg_index_i,
  input  logic [fcc_pkg::CfgDataWidth-1:0]      cfg_data_i,
  output logic                                  push_valid_o,
  input  logic                                  push_ready_i,
  output fcc_pkg::cmd_t                         push_cmd_o
);

  localparam int WideWidth = fcc_pkg::LenWidth + 1;

  logic [fcc_pkg::LenWidth-1:0] tmpl_len_q, sig_len_q;
  logic [fcc_pkg::LenWidth-1:0] lh, lx;
  logic [WideWidth-1:0]         lh_w, lx_w, lag_w, lag1, last, lh_m1;
  logic [WideWidth-1:0]         xs, xe, hs;
  logic                         accept;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmpl_len_q <= fcc_pkg::LenReset;
      sig_len_q  <= fcc_pkg::LenReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fcc_pkg::CfgTemplateLength: tmpl_len_q <= cfg_data_i;
        fcc_pkg::CfgSignalLength:   sig_len_q  <= cfg_data_i;
      endcase
    end
  end

  // zero reads as one, anything past the store depth as the depth
  always_comb begin
    lh = tmpl_len_q;
    if (tmpl_len_q == '0) begin
      lh = fcc_pkg::LenWidth'(1);
    end else if (32'(tmpl_len_q) > MaxLength) begin
      lh = fcc_pkg::LenWidth'(MaxLength);
    end
    lx = sig_len_q;
    if (sig_len_q == '0) begin
      lx = fcc_pkg::LenWidth'(1);
    end else if (32'(sig_len_q) > MaxLength) begin
      lx = fcc_pkg::LenWidth'(MaxLength);
    end
  end

  // overlap window of the requested lag
  always_comb begin
    lh_w  = WideWidth'(lh);
    lx_w  = WideWidth'(lx);
    lag_w = WideWidth'(in_lag_i);
    lag1  = lag_w + WideWidth'(1);
    last  = lh_w + lx_w - WideWidth'(2);
    lh_m1 = lh_w - WideWidth'(1);
    xs    = (lag1 > lh_w) ? lag1 - lh_w : '0;
    xe    = (lag1 < lx_w) ? lag1 : lx_w;
    hs    = (lh_m1 > lag_w) ? lh_m1 - lag_w : '0;
  end

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    push_cmd_o.kind    = fcc_pkg::CMD_COMPUTE;
    push_cmd_o.addr    = in_index_i;
    push_cmd_o.value   = in_value_i;
    push_cmd_o.lag     = in_lag_i;
    push_cmd_o.err     = lag_w > last;
    push_cmd_o.is_last = lag_w == last;
    push_cmd_o.h_start = fcc_pkg::LenWidth'(hs);
    push_cmd_o.x_start = fcc_pkg::LenWidth'(xs);
    push_cmd_o.count   = fcc_pkg::LenWidth'(xe - xs);
    push_valid_o       = 1'b0;
    unique case (fcc_pkg::op_e'(in_op_i)) inside
      fcc_pkg::OP_LOAD_TEMPLATE, fcc_pkg::OP_LOAD_SIGNAL: begin
        push_cmd_o.kind = (fcc_pkg::op_e'(in_op_i) == fcc_pkg::OP_LOAD_TEMPLATE) ?
                          fcc_pkg::CMD_LOAD_TEMPLATE : fcc_pkg::CMD_LOAD_SIGNAL;
        // positions past the store are dropped here
        push_valid_o    = accept && (32'(in_index_i) < MaxLength);
      end
      fcc_pkg::OP_COMPUTE: begin
        push_valid_o = accept;
      end
      default: begin
        push_valid_o = 1'b0;
      end
    endcase
  end

endmodule

### src/fcc_cmd_queue.sv
module fcc_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  fcc_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output fcc_pkg::cmd_t pop_cmd_o
);

  localparam int Depth    = fcc_pkg::QueueDepth;
  localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;

  fcc_pkg::cmd_t         entries_q [Depth];
  logic [PtrWidth-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrWidth:0]     fill_q;
  logic                  do_push, do_pop;

  assign push_ready_o = fill_q != (PtrWidth + 1)'(Depth);
  assign pop_valid_o  = fill_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == Depth - 1) ? '0 : wr_ptr_q + PtrWidth'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == Depth - 1) ? '0 : rd_ptr_q + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + (PtrWidth + 1)'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - (PtrWidth + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### src/fcc_back.sv
module fcc_back #(
  parameter int MaxLength   = fcc_pkg::DefaultMaxLength,
  parameter int SampleWidth = fcc_pkg::DefaultSampleWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              pop_valid_i,
  output logic                              pop_ready_o,
  input  fcc_pkg::cmd_t                     pop_cmd_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fcc_pkg::AccWidth-1:0]      out_value_o,
  output logic [fcc_pkg::LagWidth-1:0]      out_lag_o,
  output logic                              out_last_o,
  output logic                              out_status_o
);

  localparam int AddrWidth = $clog2(MaxLength);
  localparam int LenW      = fcc_pkg::LenWidth;
  localparam int AccW      = fcc_pkg::AccWidth;

  fcc_pkg::back_state_e state_q, state_d;

  logic [SampleWidth-1:0]        tmpl_mem [MaxLength];
  logic [SampleWidth-1:0]        sig_mem  [MaxLength];
  logic signed [SampleWidth-1:0] h_rd_q, x_rd_q;
  logic signed [2*SampleWidth-1:0] prod_q;
  logic [SampleWidth-1:0]        wr_value;
  logic [AddrWidth-1:0]          wr_addr;

  logic [LenW-1:0]               h_addr_q, x_addr_q, remain_q;
  logic [AccW-1:0]               acc_q;
  logic [fcc_pkg::LagWidth-1:0]  lag_q;
  logic                          is_last_q, err_q;
  logic                          rd_vld_q, prod_vld_q;

  logic pop, start, issue, out_free, load_out, we_h, we_x;

  // the load field is truncated into a narrower word, or zero-extended into a wider word
  if (SampleWidth <= fcc_pkg::SampleFieldWidth) begin : g_narrow
    assign wr_value = pop_cmd_i.value[SampleWidth-1:0];
  end else begin : g_wide
    assign wr_value = SampleWidth'(pop_cmd_i.value);
  end

  assign wr_addr = AddrWidth'(pop_cmd_i.addr);

  always_comb begin
    pop_ready_o = state_q == fcc_pkg::S_IDLE;
    pop         = pop_ready_o && pop_valid_i;
    we_h        = pop && (pop_cmd_i.kind == fcc_pkg::CMD_LOAD_TEMPLATE);
    we_x        = pop && (pop_cmd_i.kind == fcc_pkg::CMD_LOAD_SIGNAL);
    start       = pop && (pop_cmd_i.kind == fcc_pkg::CMD_COMPUTE);
    issue       = state_q == fcc_pkg::S_MAC;
    out_free    = !out_valid_o || out_ready_i;
    load_out    = (state_q == fcc_pkg::S_EMIT) && out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fcc_pkg::S_IDLE: begin
        if (start) begin
          state_d = pop_cmd_i.err ? fcc_pkg::S_EMIT : fcc_pkg::S_MAC;
        end
      end
      fcc_pkg::S_MAC: begin
        if (remain_q == LenW'(1)) begin
          state_d = fcc_pkg::S_FLUSH;
        end
      end
      fcc_pkg::S_FLUSH: begin
        if (!rd_vld_q && !prod_vld_q) begin
          state_d = fcc_pkg::S_EMIT;
        end
      end
      fcc_pkg::S_EMIT: begin
        if (out_free) begin
          state_d = fcc_pkg::S_IDLE;
        end
      end
      default: state_d = fcc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcc_pkg::S_IDLE;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= issue;
      prod_vld_q <= rd_vld_q;
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_h) begin
      tmpl_mem[wr_addr] <= wr_value;
    end
    h_rd_q <= tmpl_mem[AddrWidth'(h_addr_q)];
  end

  always_ff @(posedge clk_i) begin
    if (we_x) begin
      sig_mem[wr_addr] <= wr_value;
    end
    x_rd_q <= sig_mem[AddrWidth'(x_addr_q)];
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      h_addr_q  <= pop_cmd_i.h_start;
      x_addr_q  <= pop_cmd_i.x_start;
      remain_q  <= pop_cmd_i.count;
      lag_q     <= pop_cmd_i.lag;
      is_last_q <= pop_cmd_i.is_last;
      err_q     <= pop_cmd_i.err;
      acc_q     <= '0;
    end else begin
      if (issue) begin
        h_addr_q <= h_addr_q + LenW'(1);
        x_addr_q <= x_addr_q + LenW'(1);
        remain_q <= remain_q - LenW'(1);
      end
      // accumulator wraps at its width
      if (prod_vld_q) begin
        acc_q <= acc_q + AccW'(prod_q);
      end
    end
    if (rd_vld_q) begin
      prod_q <= h_rd_q * x_rd_q;
    end
    if (load_out) begin
      out_value_o  <= acc_q;
      out_lag_o    <= lag_q;
      out_last_o   <= is_last_q;
      out_status_o <= err_q;
    end
  end

endmodule

### tb/tb_full_cross_correlation.sv
typedef struct packed {
  logic [fcc_pkg::OpWidth-1:0]          kind;
  logic [fcc_pkg::SampleIndexWidth-1:0] index;
  logic [fcc_pkg::SampleFieldWidth-1:0] sample;
  logic [fcc_pkg::LagWidth-1:0]         lag;
} corr_cmd_t;

typedef struct packed {
  logic [fcc_pkg::AccWidth-1:0] value;
  logic [fcc_pkg::LagWidth-1:0] lag;
  logic                         last;
  logic                         status;
} corr_result_t;

class corr_scoreboard;
  logic [fcc_pkg::LenWidth-1:0]                template_len;
  logic [fcc_pkg::LenWidth-1:0]                signal_len;
  logic signed [fcc_pkg::SampleFieldWidth-1:0] template_mem [fcc_pkg::DefaultMaxLength];
  logic signed [fcc_pkg::SampleFieldWidth-1:0] signal_mem [fcc_pkg::DefaultMaxLength];
  bit                                          template_set [fcc_pkg::DefaultMaxLength];
  bit                                          signal_set [fcc_pkg::DefaultMaxLength];
  corr_result_t                                lag_results_q[$];
  int                                          errors;

  function new();
    template_len = fcc_pkg::LenReset;
    signal_len   = fcc_pkg::LenReset;
    errors       = 0;
    foreach (template_set[k]) begin
      template_set[k] = 1'b0;
      signal_set[k]   = 1'b0;
    end
  endfunction

  // a length of zero acts as one, anything past the store depth as the depth
  function int used_len(logic [fcc_pkg::LenWidth-1:0] r);
    if (r == 0) return 1;
    if (r > fcc_pkg::DefaultMaxLength) return fcc_pkg::DefaultMaxLength;
    return r;
  endfunction

  function int last_lag();
    return used_len(template_len) + used_len(signal_len) - 2;
  endfunction

  // signal range [xs, xe) and first template position for one lag
  function void overlap_bounds(input int lag, output int xs, output int xe, output int hs);
    int lh, lx;
    lh = used_len(template_len);
    lx = used_len(signal_len);
    xs = (lag + 1 > lh) ? lag + 1 - lh : 0;
    xe = (lag + 1 < lx) ? lag + 1 : lx;
    hs = (lh - 1 > lag) ? lh - 1 - lag : 0;
  endfunction

  function bit lag_is_safe(int lag);
    int xs, xe, hs, j;
    if (lag > last_lag()) return 1'b1;
    overlap_bounds(lag, xs, xe, hs);
    for (j = xs; j < xe; j++)
      if (!template_set[hs + j - xs] || !signal_set[j]) return 1'b0;
    return 1'b1;
  endfunction

  function void note_config(logic [fcc_pkg::CfgIndexWidth-1:0] idx,
                            logic [fcc_pkg::LenWidth-1:0] data);
    if (idx == fcc_pkg::CfgTemplateLength) template_len = data;
    else if (idx == fcc_pkg::CfgSignalLength) signal_len = data;
  endfunction

  function void note_input(corr_cmd_t c);
    corr_result_t r;
    int           lag, xs, xe, hs, j;
    longint       acc;
    lag = c.lag;
    if (c.kind == fcc_pkg::OP_LOAD_TEMPLATE) begin
      template_mem[c.index] = c.sample;
      template_set[c.index] = 1'b1;
    end else if (c.kind == fcc_pkg::OP_LOAD_SIGNAL) begin
      signal_mem[c.index] = c.sample;
      signal_set[c.index] = 1'b1;
    end else if (c.kind == fcc_pkg::OP_COMPUTE) begin
      r.lag = c.lag;
      if (lag > last_lag()) begin
        r.value  = '0;
        r.last   = 1'b0;
        r.status = 1'b1;
      end else begin
        overlap_bounds(lag, xs, xe, hs);
        acc = 0;
        for (j = xs; j < xe; j++)
          acc += longint'(template_mem[hs + j - xs]) * longint'(signal_mem[j]);
        r.value  = acc[fcc_pkg::AccWidth-1:0];
        r.last   = (lag == last_lag());
        r.status = 1'b0;
      end
      lag_results_q.push_back(r);
    end
  endfunction

  function int pending();
    return lag_results_q.size();
  endfunction

  task report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_result(logic [fcc_pkg::OutDataWidth-1:0] data, logic last, logic status);
    corr_result_t                 want;
    logic [fcc_pkg::AccWidth-1:0] got_value;
    logic [fcc_pkg::LagWidth-1:0] got_lag;
    string                        msg;
    got_value = data[fcc_pkg::AccWidth-1:0];
    got_lag   = data[fcc_pkg::AccWidth +: fcc_pkg::LagWidth];
    if (lag_results_q.size() == 0) begin
      report_mismatch($sformatf("result for lag %0d with nothing pending", got_lag));
      return;
    end
    want = lag_results_q.pop_front();
    msg  = "";
    if (got_value !== want.value)
      msg = {msg, $sformatf(" value %0d want %0d", $signed(got_value), $signed(want.value))};
    if (got_lag !== want.lag)
      msg = {msg, $sformatf(" lag %0d want %0d", got_lag, want.lag)};
    if (last !== want.last)
      msg = {msg, $sformatf(" last %0b want %0b", last, want.last)};
    if (status !== want.status)
      msg = {msg, $sformatf(" status %0b want %0b", status, want.status)};
    if (msg != "") report_mismatch($sformatf("lag %0d:%s", want.lag, msg));
  endtask
endclass

module tb_full_cross_correlation;

  localparam logic [fcc_pkg::OpWidth-1:0] OpUnused = 2'd3;
  localparam int MaxLen       = fcc_pkg::DefaultMaxLength;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 16;
  localparam int TailCycles   = 1100;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  logic [fcc_pkg::InDataWidth-1:0]     s_axis_tdata;
  logic [fcc_pkg::OpWidth-1:0]         s_axis_tuser;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  logic [fcc_pkg::OutDataWidth-1:0]    m_axis_tdata;
  logic                                m_axis_tlast;
  logic                                m_axis_tuser;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [fcc_pkg::CfgIndexWidth-1:0]   cfg_index_i;
  logic [fcc_pkg::CfgDataWidth-1:0]    cfg_data_i;

  corr_scoreboard sb = new();
  int idle_pct;
  int items_sent;
  int hold_requests;
  int hold_served;

  full_cross_correlation dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #16000000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random back-pressure plus the occasional long hold
  initial begin : result_sink
    int hold_left;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_served < hold_requests) begin
        hold_left = HoldCycles;
        hold_served++;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
      end
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  // entered and left at a falling edge
  task automatic push_item(input logic [fcc_pkg::OpWidth-1:0] op, input logic [31:0] index,
                           input logic [31:0] sample, input logic [31:0] lag);
    logic [fcc_pkg::InDataWidth-1:0] word;
    corr_cmd_t                       cmd;
    cmd.kind   = op;
    cmd.index  = index[fcc_pkg::SampleIndexWidth-1:0];
    cmd.sample = sample[fcc_pkg::SampleFieldWidth-1:0];
    cmd.lag    = lag[fcc_pkg::LagWidth-1:0];
    word = '0;
    word[fcc_pkg::InIndexLsb +: fcc_pkg::SampleIndexWidth] = cmd.index;
    word[fcc_pkg::InValueLsb +: fcc_pkg::SampleFieldWidth] = cmd.sample;
    word[fcc_pkg::InLagLsb +: fcc_pkg::LagWidth]           = cmd.lag;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(cmd);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_lengths(input logic [fcc_pkg::LenWidth-1:0] lh,
                               input logic [fcc_pkg::LenWidth-1:0] lx);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= fcc_pkg::CfgTemplateLength;
    cfg_data_i  <= lh;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.note_config(fcc_pkg::CfgTemplateLength, lh);
    @(negedge clk_i);
    cfg_index_i <= fcc_pkg::CfgSignalLength;
    cfg_data_i  <= lx;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.note_config(fcc_pkg::CfgSignalLength, lx);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // loads leave no trace on the output, so give the engine SettleCycles more
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(19))
      0:       return 32'h8000;
      1:       return 32'h7fff;
      2:       return 32'h0000;
      3:       return 32'hffff;
      default: return $urandom;
    endcase
  endfunction

  // a lag whose overlap touches only written entries, or -1 if none turned up
  function automatic int pick_lag();
    int last, edge_span, cand, tries;
    last      = sb.last_lag();
    edge_span = (last < 7) ? last : 7;
    for (tries = 0; tries < 8; tries++) begin
      case ($urandom_range(19))
        0, 1, 2: cand = $urandom_range(2047, last + 1);
        3, 4:    cand = last;
        5, 6, 7: cand = $urandom_range(1) ? $urandom_range(edge_span, 0)
                                          : last - $urandom_range(edge_span, 0);
        default: cand = $urandom_range(last, 0);
      endcase
      if (sb.lag_is_safe(cand)) return cand;
    end
    return -1;
  endfunction

  task automatic random_item();
    int                          sel, lag, len;
    logic [fcc_pkg::OpWidth-1:0] op;
    sel = $urandom_range(99);
    if (sel < 4) begin
      push_item(OpUnused, $urandom, $urandom, $urandom);
    end else begin
      lag = (sel < 50) ? pick_lag() : -1;
      if (lag >= 0) begin
        push_item(fcc_pkg::OP_COMPUTE, $urandom, $urandom, lag);
      end else begin
        op  = $urandom_range(1) ? fcc_pkg::OP_LOAD_SIGNAL : fcc_pkg::OP_LOAD_TEMPLATE;
        len = sb.used_len((op == fcc_pkg::OP_LOAD_SIGNAL) ? sb.signal_len : sb.template_len);
        push_item(op, ($urandom_range(9) < 7) ? $urandom_range(len - 1) : $urandom_range(MaxLen - 1),
                  rand_sample(), $urandom);
      end
    end
  endtask

  // short stores are filled whole, long ones only at both ends
  task automatic preload();
    int lh, lx, k;
    lh = sb.used_len(sb.template_len);
    lx = sb.used_len(sb.signal_len);
    for (k = 0; k < lh; k++)
      if ((lh <= 32 || k < 8 || k >= lh - 8) && !sb.template_set[k])
        push_item(fcc_pkg::OP_LOAD_TEMPLATE, k, rand_sample(), $urandom);
    for (k = 0; k < lx; k++)
      if ((lx <= 32 || k < 8 || k >= lx - 8) && !sb.signal_set[k])
        push_item(fcc_pkg::OP_LOAD_SIGNAL, k, rand_sample(), $urandom);
  endtask

  task automatic run_phase(input logic [fcc_pkg::LenWidth-1:0] lh,
                           input logic [fcc_pkg::LenWidth-1:0] lx,
                           input int budget, input bit with_hold);
    int first;
    bit held;
    held = 1'b0;
    write_lengths(lh, lx);
    first = items_sent;
    preload();
    while (items_sent - first < budget) begin
      if (with_hold && !held && items_sent - first >= 40) begin
        hold_requests++;
        held = 1'b1;
      end
      random_item();
    end
    s_axis_tvalid <= 1'b0;
    drain();
  endtask

  initial begin : stimulus
    int p;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    idle_pct      = 28;
    items_sent    = 0;
    hold_requests = 0;
    hold_served   = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // full length after reset: extreme samples at both ends of each store
    push_item(fcc_pkg::OP_LOAD_TEMPLATE, 1023, 32'h8000, 0);
    push_item(fcc_pkg::OP_LOAD_SIGNAL, 0, 32'h8000, 2047);
    push_item(fcc_pkg::OP_COMPUTE, 0, 0, 0);
    push_item(fcc_pkg::OP_LOAD_TEMPLATE, 0, 32'h7fff, 0);
    push_item(fcc_pkg::OP_LOAD_SIGNAL, 1023, 32'h7fff, 0);
    push_item(fcc_pkg::OP_COMPUTE, 1023, 32'hffff, 2046);
    push_item(fcc_pkg::OP_COMPUTE, 0, 0, 2047);
    push_item(OpUnused, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    push_item(fcc_pkg::OP_LOAD_TEMPLATE, 1022, 32'h7fff, 0);
    push_item(fcc_pkg::OP_LOAD_SIGNAL, 1, 32'h8000, 0);
    push_item(fcc_pkg::OP_COMPUTE, 0, 0, 1);
    push_item(fcc_pkg::OP_LOAD_TEMPLATE, 1, 32'h8000, 0);
    push_item(fcc_pkg::OP_LOAD_SIGNAL, 1022, 32'h0000, 0);
    push_item(fcc_pkg::OP_COMPUTE, 0, 0, 2045);
    push_item(OpUnused, 0, 0, 0);
    push_item(fcc_pkg::OP_COMPUTE, 0, 0, 2046);
    s_axis_tvalid <= 1'b0;
    drain();

    run_phase(11'd0, 11'd0, 30, 1'b0);       // both read as one
    run_phase(11'd1, 11'd24, 50, 1'b0);
    run_phase(11'd2047, 11'd3, 50, 1'b0);    // template clamps to full depth
    run_phase(11'd5, 11'd1025, 50, 1'b0);
    run_phase(11'd16, 11'd16, 90, 1'b1);
    run_phase(11'd1024, 11'd1024, 60, 1'b0);
    for (p = 0; p < 3; p++)
      run_phase(11'($urandom_range(32, 1)), 11'($urandom_range(32, 1)), 60, 1'b0);
    idle_pct = 0;
    run_phase(11'd7, 11'd9, 70, 1'b0);

    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
src/fcc_pkg.sv
src/fcc_front.sv
src/fcc_cmd_queue.sv
src/fcc_back.sv
src/full_cross_correlation.sv
tb/tb_full_cross_correlation.sv
